// ===== rtl/day_count_to_calendar_date_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the day count to calendar date core
// ----------------------------------------------------------------------------
`ifndef DAY_COUNT_TO_CALENDAR_DATE_CORE_MACROS_SVH
`define DAY_COUNT_TO_CALENDAR_DATE_CORE_MACROS_SVH

// same-cycle implication, masked during reset
`define DCCD_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, masked during reset
`define DCCD_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/dccd_pkg.sv =====
// ----------------------------------------------------------------------------
// dccd_pkg
// Widths, constants, stage types and small tables for the day count to
// calendar date core.
// ----------------------------------------------------------------------------
package dccd_pkg;

   localparam int DAY_NUMBER_W = 32;
   localparam int YEAR_W       = 24;
   localparam int MONTH_W      = 4;
   localparam int MDAY_W       = 5;
   localparam int YDAY_W       = 9;
   localparam int WDAY_W       = 3;
   localparam int NUM_STAGES   = 10;

   // rebias: day number + 2^31 + this = days from 1 March year 0, plus 14700 eras
   localparam logic [32:0] ZP_OFFSET    = 33'd836151;
   localparam logic [17:0] DAYS_PER_ERA = 18'd146097;
   localparam logic [15:0] ERA_BIAS     = 16'd14700;
   // reciprocals: floor(2^37/146097), ceil(2^29/1460), ceil(2^28/365)
   localparam logic [19:0] RECIP_ERA    = 20'd940737;
   localparam logic [18:0] RECIP_1460   = 19'd367720;
   localparam logic [19:0] RECIP_365    = 20'd735440;

   typedef struct packed {
      logic [32:0] zp;
      logic [6:0]  wsum;
   } st1_type;

   typedef struct packed {
      logic [32:0] zp;
      logic [14:0] q0;
      logic [2:0]  wd;
   } st2_type;

   typedef struct packed {
      logic [18:0] r;
      logic [14:0] q0;
      logic [2:0]  wd;
   } st3_type;

   typedef struct packed {
      logic [17:0] doe;
      logic [15:0] era;
      logic [2:0]  wd;
   } st4_type;

   typedef struct packed {
      logic [17:0] doe;
      logic [6:0]  a1;
      logic [2:0]  b;
      logic        c;
      logic [23:0] ybase;
      logic [2:0]  wd;
   } st5_type;

   typedef struct packed {
      logic [17:0] doe;
      logic [17:0] t;
      logic [23:0] ybase;
      logic [2:0]  wd;
   } st6_type;

   typedef struct packed {
      logic [17:0] doe;
      logic [8:0]  yoe;
      logic [23:0] ybase;
      logic [2:0]  wd;
   } st7_type;

   typedef struct packed {
      logic [8:0]  doy;
      logic [8:0]  yoe;
      logic [23:0] ybase;
      logic [2:0]  wd;
   } st8_type;

   typedef struct packed {
      logic [3:0]  mon;
      logic [4:0]  mday;
      logic        leap;
      logic [23:0] year;
      logic [2:0]  wd;
   } st9_type;

   typedef struct packed {
      logic [23:0] year;
      logic [3:0]  mon;
      logic [4:0]  mday;
      logic [8:0]  yday;
      logic [2:0]  wd;
   } st10_type;

   // first day of each month in a year that starts on 1 March
   function automatic logic [8:0] mar_start(input logic [3:0] mp);
      logic [8:0] s;
      case (mp)
         4'd0:    s = 9'd0;
         4'd1:    s = 9'd31;
         4'd2:    s = 9'd61;
         4'd3:    s = 9'd92;
         4'd4:    s = 9'd122;
         4'd5:    s = 9'd153;
         4'd6:    s = 9'd184;
         4'd7:    s = 9'd214;
         4'd8:    s = 9'd245;
         4'd9:    s = 9'd275;
         4'd10:   s = 9'd306;
         4'd11:   s = 9'd337;
         default: s = 9'd0;
      endcase
      return s;
   endfunction

   // zero-based day of year of the first of a month, 1 is January
   function automatic logic [8:0] month_start(input logic leap, input logic [3:0] mon);
      logic [8:0] s;
      case (mon)
         4'd1:    s = 9'd0;
         4'd2:    s = 9'd31;
         4'd3:    s = 9'd59;
         4'd4:    s = 9'd90;
         4'd5:    s = 9'd120;
         4'd6:    s = 9'd151;
         4'd7:    s = 9'd181;
         4'd8:    s = 9'd212;
         4'd9:    s = 9'd243;
         4'd10:   s = 9'd273;
         4'd11:   s = 9'd304;
         4'd12:   s = 9'd334;
         default: s = 9'd0;
      endcase
      if (leap && (mon > 4'd2)) begin
         s = s + 9'd1;
      end
      return s;
   endfunction

   // residue mod 7 of a 7-bit octal digit sum (8 = 1 mod 7)
   function automatic logic [2:0] mod7_fold(input logic [6:0] v);
      logic [3:0] f;
      f = 4'(v[6]) + 4'(v[5:3]) + 4'(v[2:0]);
      if (f >= 4'd14) begin
         f = f - 4'd14;
      end else if (f >= 4'd7) begin
         f = f - 4'd7;
      end
      return f[2:0];
   endfunction

endpackage

// ===== rtl/day_count_to_calendar_date_core.sv =====
// ----------------------------------------------------------------------------
// day_count_to_calendar_date_core
// Each stage is one register on the way from accepted request to response valid.
// Throughput: one transaction per cycle while rsp_stall is low; bubbles close up under rsp_stall.
// Reset clears only the stage valid bits; the stage data registers are not reset.
// Signed day number since 30 Dec 1899 in, proleptic Gregorian date out.
// ----------------------------------------------------------------------------
`include "day_count_to_calendar_date_core_macros.svh"

module day_count_to_calendar_date_core (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_stall,
   input  logic signed [dccd_pkg::DAY_NUMBER_W-1:0]   req_day_number,
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output logic signed [dccd_pkg::YEAR_W-1:0]         rsp_year,
   output logic        [dccd_pkg::MONTH_W-1:0]        rsp_month,
   output logic        [dccd_pkg::MDAY_W-1:0]         rsp_day_of_month,
   output logic        [dccd_pkg::YDAY_W-1:0]         rsp_day_of_year,
   output logic        [dccd_pkg::WDAY_W-1:0]         rsp_weekday
);
   import dccd_pkg::*;

   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] adv;

   st1_type  s1_in,  s1_ff;
   st2_type  s2_in,  s2_ff;
   st3_type  s3_in,  s3_ff;
   st4_type  s4_in,  s4_ff;
   st5_type  s5_in,  s5_ff;
   st6_type  s6_in,  s6_ff;
   st7_type  s7_in,  s7_ff;
   st8_type  s8_in,  s8_ff;
   st9_type  s9_in,  s9_ff;
   st10_type s10_in, s10_ff;

   // a stage may load when empty or when the one after it moves on
   always_comb begin
      adv[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || !rsp_stall;
      for (int i = NUM_STAGES-2; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
   end

   assign req_stall = !adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int i = 1; i < NUM_STAGES; i++) begin
            if (adv[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   // stage 1: rebias to an unsigned era count; octal digit sum for the weekday
   logic [31:0] ubias;
   logic [6:0]  wacc;
   always_comb begin
      ubias = {~req_day_number[31], req_day_number[30:0]};
      wacc  = 7'd4;  // Saturday at day zero, with 2^31 mod 7 folded in
      for (int i = 0; i < 10; i++) begin
         wacc = wacc + 7'(ubias[3*i +: 3]);
      end
      wacc     = wacc + 7'(ubias[31:30]);
      s1_in.zp   = {1'b0, ubias} + ZP_OFFSET;
      s1_in.wsum = wacc;
   end

   // stage 2: era estimate by reciprocal, may be up to two low
   logic [35:0] era_prod;
   always_comb begin
      era_prod = {20'd0, s1_ff.zp[32:17]} * {16'd0, RECIP_ERA};
      s2_in.zp = s1_ff.zp;
      s2_in.q0 = era_prod[34:20];
      s2_in.wd = mod7_fold(s1_ff.wsum);
   end

   // stage 3: remainder against the estimate
   logic [32:0] era_days;
   logic [32:0] era_rem;
   always_comb begin
      era_days = {18'd0, s2_ff.q0} * {15'd0, DAYS_PER_ERA};
      era_rem  = s2_ff.zp - era_days;
      s3_in.r  = era_rem[18:0];
      s3_in.q0 = s2_ff.q0;
      s3_in.wd = s2_ff.wd;
   end

   // stage 4: two correction steps, then remove the era bias
   logic [18:0] r1, r2;
   logic [14:0] q1, q2;
   always_comb begin
      r1 = s3_ff.r;
      q1 = s3_ff.q0;
      if (s3_ff.r >= 19'(DAYS_PER_ERA)) begin
         r1 = s3_ff.r - 19'(DAYS_PER_ERA);
         q1 = s3_ff.q0 + 15'd1;
      end
      r2 = r1;
      q2 = q1;
      if (r1 >= 19'(DAYS_PER_ERA)) begin
         r2 = r1 - 19'(DAYS_PER_ERA);
         q2 = q1 + 15'd1;
      end
      s4_in.doe = r2[17:0];
      s4_in.era = {1'b0, q2} - ERA_BIAS;
      s4_in.wd  = s3_ff.wd;
   end

   // stage 5: leap corrections within the era; era * 400 by shifts
   logic [36:0] p1460;
   logic [23:0] era_x;
   always_comb begin
      p1460     = {19'd0, s4_ff.doe} * {18'd0, RECIP_1460};
      era_x     = {{8{s4_ff.era[15]}}, s4_ff.era};
      s5_in.doe = s4_ff.doe;
      s5_in.a1  = p1460[35:29];
      s5_in.b   = 3'(s4_ff.doe >= 18'd36524) + 3'(s4_ff.doe >= 18'd73048)
                + 3'(s4_ff.doe >= 18'd109572) + 3'(s4_ff.doe >= 18'd146096);
      s5_in.c   = (s4_ff.doe == 18'd146096);
      s5_in.ybase = (era_x << 8) + (era_x << 7) + (era_x << 4);
      s5_in.wd  = s4_ff.wd;
   end

   // stage 6: day count with leap days removed
   logic [18:0] t_sum;
   always_comb begin
      t_sum = 19'(s5_ff.doe) - 19'(s5_ff.a1) + 19'(s5_ff.b) - 19'(s5_ff.c);
      s6_in.doe   = s5_ff.doe;
      s6_in.t     = t_sum[17:0];
      s6_in.ybase = s5_ff.ybase;
      s6_in.wd    = s5_ff.wd;
   end

   // stage 7: year of era
   logic [37:0] p365;
   always_comb begin
      p365 = {20'd0, s6_ff.t} * {18'd0, RECIP_365};
      s7_in.doe   = s6_ff.doe;
      s7_in.yoe   = p365[36:28];
      s7_in.ybase = s6_ff.ybase;
      s7_in.wd    = s6_ff.wd;
   end

   // stage 8: day within the March-based year
   logic [1:0]  cent;
   logic [18:0] year_days;
   logic [18:0] doy_full;
   always_comb begin
      cent = 2'(s7_ff.yoe >= 9'd100) + 2'(s7_ff.yoe >= 9'd200) + 2'(s7_ff.yoe >= 9'd300);
      year_days = 19'(s7_ff.yoe) * 19'd365 + 19'(s7_ff.yoe[8:2]);
      doy_full  = 19'(s7_ff.doe) + 19'(cent) - year_days;
      s8_in.doy   = doy_full[8:0];
      s8_in.yoe   = s7_ff.yoe;
      s8_in.ybase = s7_ff.ybase;
      s8_in.wd    = s7_ff.wd;
   end

   // stage 9: month, day of month, calendar year and leap flag
   logic [3:0] mp;
   logic [8:0] mday_full;
   logic       jan_feb;
   logic [9:0] yy;
   always_comb begin
      mp = 4'd0;
      for (int k = 1; k < 12; k++) begin
         mp = mp + 4'(s8_ff.doy >= mar_start(4'(k)));
      end
      mday_full = s8_ff.doy - mar_start(mp) + 9'd1;
      jan_feb   = (mp >= 4'd10);
      // year within the 400-year cycle decides leap; 0 and 400 both qualify
      yy = 10'(s8_ff.yoe) + 10'(jan_feb);
      s9_in.mon  = jan_feb ? (mp - 4'd9) : (mp + 4'd3);
      s9_in.mday = mday_full[4:0];
      s9_in.leap = (yy[1:0] == 2'd0) && !(yy inside {10'd100, 10'd200, 10'd300});
      s9_in.year = s8_ff.ybase + 24'(s8_ff.yoe) + 24'(jan_feb);
      s9_in.wd   = s8_ff.wd;
   end

   // stage 10: day of year, output register
   always_comb begin
      s10_in.year = s9_ff.year;
      s10_in.mon  = s9_ff.mon;
      s10_in.mday = s9_ff.mday;
      s10_in.yday = month_start(s9_ff.leap, s9_ff.mon) + 9'(s9_ff.mday) - 9'd1;
      s10_in.wd   = s9_ff.wd;
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s1_ff <= s1_in;
      end
      if (adv[1]) begin
         s2_ff <= s2_in;
      end
      if (adv[2]) begin
         s3_ff <= s3_in;
      end
      if (adv[3]) begin
         s4_ff <= s4_in;
      end
      if (adv[4]) begin
         s5_ff <= s5_in;
      end
      if (adv[5]) begin
         s6_ff <= s6_in;
      end
      if (adv[6]) begin
         s7_ff <= s7_in;
      end
      if (adv[7]) begin
         s8_ff <= s8_in;
      end
      if (adv[8]) begin
         s9_ff <= s9_in;
      end
      if (adv[9]) begin
         s10_ff <= s10_in;
      end
   end

   assign rsp_valid        = vld_ff[NUM_STAGES-1];
   assign rsp_year         = s10_ff.year;
   assign rsp_month        = s10_ff.mon;
   assign rsp_day_of_month = s10_ff.mday;
   assign rsp_day_of_year  = s10_ff.yday;
   assign rsp_weekday      = s10_ff.wd;

   `DCCD_ASSERT_IMP(a_month_range, rsp_valid, (rsp_month >= 4'd1) && (rsp_month <= 4'd12), "month out of range")
   `DCCD_ASSERT_IMP(a_january_yday, rsp_valid && (rsp_month == 4'd1), rsp_day_of_year == (9'(rsp_day_of_month) - 9'd1), "January day of year mismatch")
   `DCCD_ASSERT_IMP(a_weekday_range, rsp_valid, rsp_weekday <= 3'd6, "weekday out of range")
   `DCCD_ASSERT_NXT(a_entry_taken, req_valid && !req_stall, vld_ff[0], "accepted transaction missing at first stage")

endmodule

// ===== verif/tb_day_count_to_calendar_date_core.sv =====
// ----------------------------------------------------------------------------
// tb_day_count_to_calendar_date_core
// Feeds signed day serial numbers through the calendar date core and checks
// every response against a tabled date or the in-bench Gregorian predictor.
// The tabled day numbers come first, then random traffic aimed at era and
// century boundaries, the year-zero region and both ends of the input range.
// Both sides idle at random, with one quiet stretch and one long hold-off.
// ----------------------------------------------------------------------------
module tb_day_count_to_calendar_date_core;

   import dccd_pkg::*;

   localparam int RANDOM_ITEMS   = 1730;
   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_CYCLES   = 16;
   localparam int IDLE_PERCENT   = 16;
   // day serial of 1 March in year 0, and days per 400-year cycle
   localparam longint MARCH_ZERO = -693899;
   localparam longint ERA_DAYS   = 146097;

   localparam int MONTH_FIRST [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304,
                                       334};

   typedef struct packed {
      logic signed [YEAR_W-1:0] year;
      logic [MONTH_W-1:0]       month;
      logic [MDAY_W-1:0]        mday;
      logic [YDAY_W-1:0]        yday;
      logic [WDAY_W-1:0]        wday;
   } cal_date_t;

   typedef struct packed {
      logic signed [DAY_NUMBER_W-1:0] day;
      cal_date_t                      date;
   } pending_date_t;

   typedef struct packed {
      logic signed [DAY_NUMBER_W-1:0] day;
      bit                             known;
      logic signed [YEAR_W-1:0]       year;
      logic [MONTH_W-1:0]             month;
      logic [MDAY_W-1:0]              mday;
      logic [YDAY_W-1:0]              yday;
      logic [WDAY_W-1:0]              wday;
   } day_vector_t;

   localparam int NUM_VECTORS = 22;

   // known dates where the answer is plain; others go through the predictor
   day_vector_t day_vectors [NUM_VECTORS] = '{
      '{32'sd0,           1'b1, 24'sd1899, 4'd12, 5'd30, 9'd363, 3'd6},
      '{32'sd1,           1'b1, 24'sd1899, 4'd12, 5'd31, 9'd364, 3'd0},
      '{32'sd2,           1'b1, 24'sd1900, 4'd1,  5'd1,  9'd0,   3'd1},
      '{-32'sd1,          1'b1, 24'sd1899, 4'd12, 5'd29, 9'd362, 3'd5},
      '{32'sd60,          1'b1, 24'sd1900, 4'd2,  5'd28, 9'd58,  3'd3},
      '{32'sd61,          1'b1, 24'sd1900, 4'd3,  5'd1,  9'd59,  3'd4},
      '{32'sd36526,       1'b1, 24'sd2000, 4'd1,  5'd1,  9'd0,   3'd6},
      '{32'sd36585,       1'b1, 24'sd2000, 4'd2,  5'd29, 9'd59,  3'd2},
      '{32'sd36586,       1'b1, 24'sd2000, 4'd3,  5'd1,  9'd60,  3'd3},
      '{32'sd36891,       1'b1, 24'sd2000, 4'd12, 5'd31, 9'd365, 3'd0},
      '{32'sh80000000,    1'b0, '0, '0, '0, '0, '0},
      '{32'sh80000001,    1'b0, '0, '0, '0, '0, '0},
      '{32'sh7FFFFFFF,    1'b0, '0, '0, '0, '0, '0},
      '{32'sh7FFFFFFE,    1'b0, '0, '0, '0, '0, '0},
      '{32'sh55555555,    1'b0, '0, '0, '0, '0, '0},
      '{32'shAAAAAAAA,    1'b0, '0, '0, '0, '0, '0},
      '{-32'sd693899,     1'b0, '0, '0, '0, '0, '0},
      '{-32'sd693900,     1'b0, '0, '0, '0, '0, '0},
      '{-32'sd693959,     1'b0, '0, '0, '0, '0, '0},
      '{-32'sd693960,     1'b0, '0, '0, '0, '0, '0},
      '{32'sd2958465,     1'b0, '0, '0, '0, '0, '0},
      '{-32'sd146097,     1'b0, '0, '0, '0, '0, '0}
   };

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   logic signed [DAY_NUMBER_W-1:0]   req_day_number;
   logic                             rsp_valid;
   logic                             rsp_stall;
   logic signed [YEAR_W-1:0]         rsp_year;
   logic [MONTH_W-1:0]               rsp_month;
   logic [MDAY_W-1:0]                rsp_day_of_month;
   logic [YDAY_W-1:0]                rsp_day_of_year;
   logic [WDAY_W-1:0]                rsp_weekday;

   pending_date_t pending_dates [$];
   int            mismatch_count;
   int            sent_count;
   int            checked_count;
   bit            idle_on;
   bit            hold_request;

   day_count_to_calendar_date_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_day_number   (req_day_number),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_year         (rsp_year),
      .rsp_month        (rsp_month),
      .rsp_day_of_month (rsp_day_of_month),
      .rsp_day_of_year  (rsp_day_of_year),
      .rsp_weekday      (rsp_weekday)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1000000;
      $display("DONE: errors detected");
      $finish;
   end

   // Era arithmetic on 400-year cycles counted from 1 March of year 0; floor
   // division throughout so that negative serials count back correctly.
   function automatic cal_date_t gregorian_from_day(input logic signed [DAY_NUMBER_W-1:0] dn);
      longint    days;
      longint    z;
      longint    era;
      longint    doe;
      longint    yoe;
      longint    yr;
      longint    doy;
      longint    mp;
      longint    mon;
      longint    mday;
      longint    wd;
      longint    yday;
      bit        leap;
      cal_date_t d;
      days = longint'(dn);
      wd = (days + 363) % 7;
      if (wd < 0) begin
         wd = wd + 7;
      end
      z   = days - MARCH_ZERO;
      era = ((z >= 0) ? z : z - (ERA_DAYS - 1)) / ERA_DAYS;
      doe = z - era * ERA_DAYS;
      yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      yr  = yoe + era * 400;
      doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp  = (5 * doy + 2) / 153;
      mday = doy - (153 * mp + 2) / 5 + 1;
      mon = (mp < 10) ? mp + 3 : mp - 9;
      if (mon <= 2) begin
         yr = yr + 1;
      end
      leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
      yday = MONTH_FIRST[int'(mon) - 1] + mday - 1;
      if (leap && mon > 2) begin
         yday = yday + 1;
      end
      d.year  = YEAR_W'(yr);
      d.month = MONTH_W'(mon);
      d.mday  = MDAY_W'(mday);
      d.yday  = YDAY_W'(yday);
      d.wday  = WDAY_W'(wd);
      return d;
   endfunction

   task automatic log_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   // Starts and ends at a falling edge; the expected date is queued once the
   // transaction is taken.
   task automatic send_day(input logic signed [DAY_NUMBER_W-1:0] dn, input cal_date_t want);
      while (idle_on && ($urandom_range(99) < IDLE_PERCENT)) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid      = 1'b1;
      req_day_number = dn;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      pending_dates.push_back('{dn, want});
      sent_count++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // receiver: random stalls, or one long counted hold-off on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall    = 1'b0;
            hold_request = 1'b0;
         end else if (idle_on) begin
            rsp_stall = ($urandom_range(99) < IDLE_PERCENT);
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      pending_date_t exp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_dates.size() == 0) begin
            log_mismatch($sformatf("response with nothing outstanding (year %0d)", rsp_year));
         end else begin
            exp = pending_dates.pop_front();
            checked_count++;
            if (rsp_year !== exp.date.year)
               log_mismatch($sformatf("day %0d: year %0d, want %0d",
                                      exp.day, rsp_year, exp.date.year));
            if (rsp_month !== exp.date.month)
               log_mismatch($sformatf("day %0d: month %0d, want %0d",
                                      exp.day, rsp_month, exp.date.month));
            if (rsp_day_of_month !== exp.date.mday)
               log_mismatch($sformatf("day %0d: day of month %0d, want %0d",
                                      exp.day, rsp_day_of_month, exp.date.mday));
            if (rsp_day_of_year !== exp.date.yday)
               log_mismatch($sformatf("day %0d: day of year %0d, want %0d",
                                      exp.day, rsp_day_of_year, exp.date.yday));
            if (rsp_weekday !== exp.date.wday)
               log_mismatch($sformatf("day %0d: weekday %0d, want %0d",
                                      exp.day, rsp_weekday, exp.date.wday));
         end
      end
   end

   initial begin
      cal_date_t                      want;
      logic signed [DAY_NUMBER_W-1:0] dn;
      longint                         pick;
      mismatch_count = 0;
      sent_count     = 0;
      checked_count  = 0;
      idle_on        = 1'b1;
      hold_request   = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_day_number = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (day_vectors[i]) begin
         if (day_vectors[i].known) begin
            want = '{day_vectors[i].year, day_vectors[i].month, day_vectors[i].mday,
                     day_vectors[i].yday, day_vectors[i].wday};
         end else begin
            want = gregorian_from_day(day_vectors[i].day);
         end
         send_day(day_vectors[i].day, want);
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // quiet stretch with no idling on either side
         idle_on = !(n >= 1000 && n < 1300);
         // long hold-off at the receiver while transactions keep coming
         if (n == 600) begin
            hold_request = 1'b1;
         end
         case ($urandom_range(9))
            0, 1, 2: pick = longint'(int'($urandom()));
            3, 4, 5: pick = longint'($urandom_range(2 * 146097)) - ERA_DAYS;
            6, 7: begin
               // near era, century and leap-year boundaries
               pick = MARCH_ZERO + (longint'($urandom_range(28000)) - 14000) * ERA_DAYS
                      + longint'($urandom_range(3)) * 36524
                      + longint'($urandom_range(800)) - 400;
            end
            8: begin
               if ($urandom_range(1))
                  pick = -longint'(32'h80000000) + longint'($urandom_range(2000));
               else
                  pick = longint'(32'h7FFFFFFF) - longint'($urandom_range(2000));
            end
            default: pick = MARCH_ZERO + longint'($urandom_range(1600)) - 800;
         endcase
         dn = DAY_NUMBER_W'(pick);
         send_day(dn, gregorian_from_day(dn));
      end

      while (pending_dates.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Converted %0d day numbers (%0d directed), %0d dates checked.",
               sent_count, NUM_VECTORS, checked_count);
      $display("Covered both range ends, year zero, era edges and a %0d-cycle hold-off.",
               HOLD_CYCLES);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
